>>> hw/rtl/sccb_bit_master_defines.svh
// ----------------------------------------------------------------------------
// sccb_bit_master assertion macros
// Shared concurrent assertion forms for the camera-bus bit master checks.
// ----------------------------------------------------------------------------
`ifndef SCCB_BIT_MASTER_DEFINES_SVH
`define SCCB_BIT_MASTER_DEFINES_SVH

// same-cycle implication, sampled on the block clock, off during reset
`define SBM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// next-cycle implication, sampled on the block clock, off during reset
`define SBM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

>>> hw/rtl/sbm_pkg.sv
// ----------------------------------------------------------------------------
// sbm_pkg
// Types, codes and helpers shared by the camera-bus bit master.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbm_pkg;

   // width of the tick counter per phase
   localparam int WAIT_WIDTH = 16;
   // configuration register width and index width
   localparam int CSR_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 2;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_WAIT  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHORT_WAIT = 2'd1;

   // register reset values
   localparam logic [CSR_WIDTH-1:0] LONG_WAIT_RESET  = 16'd500;
   localparam logic [CSR_WIDTH-1:0] SHORT_WAIT_RESET = 16'd100;

   // command codes carried in the request word
   localparam logic [2:0] KIND_TICK  = 3'd0;
   localparam logic [2:0] KIND_START = 3'd1;
   localparam logic [2:0] KIND_STOP  = 3'd2;
   localparam logic [2:0] KIND_WRITE = 3'd3;
   localparam logic [2:0] KIND_READ  = 3'd4;
   localparam logic [2:0] KIND_NACK  = 3'd5;

   // bits per byte on the bus
   localparam logic [3:0] BYTE_BITS = 4'd8;

   // bus sequencer phases
   typedef enum logic [23:0] {
      PH_IDLE  = 24'h000001,
      PH_S_DH  = 24'h000002,
      PH_S_CH  = 24'h000004,
      PH_S_DL  = 24'h000008,
      PH_S_CL  = 24'h000010,
      PH_P_DL  = 24'h000020,
      PH_P_CH  = 24'h000040,
      PH_P_DH  = 24'h000080,
      PH_N_DH  = 24'h000100,
      PH_N_CH  = 24'h000200,
      PH_N_CL  = 24'h000400,
      PH_N_DL  = 24'h000800,
      PH_W_BIT = 24'h001000,
      PH_W_CH  = 24'h002000,
      PH_W_CL  = 24'h004000,
      PH_W_GAP = 24'h008000,
      PH_W_REL = 24'h010000,
      PH_W_ACH = 24'h020000,
      PH_W_ACL = 24'h040000,
      PH_R_REL = 24'h080000,
      PH_R_PRE = 24'h100000,
      PH_R_CH  = 24'h200000,
      PH_R_CL  = 24'h400000,
      PH_FIN   = 24'h800000
   } phase_type;

   // one result word, state after the tick
   typedef struct packed {
      logic       clock_pin;
      logic       data_pin_out;
      logic       data_drive_enable;
      logic       busy_res;
      logic       done_res;
      logic       ack_ok;
      logic [7:0] read_byte;
   } result_type;

   // counter load for a wait register: zero acts as one, saturate to counter range
   function automatic logic [WAIT_WIDTH-1:0] wait_load(input logic [CSR_WIDTH-1:0] r);
      logic [WAIT_WIDTH+CSR_WIDTH-1:0] w;
      logic [WAIT_WIDTH+CSR_WIDTH-1:0] cmax;
      w    = {{WAIT_WIDTH{1'b0}}, r};
      cmax = {{CSR_WIDTH{1'b0}}, {WAIT_WIDTH{1'b1}}};
      if (w > cmax) begin
         w = cmax;
      end
      if (w == '0) begin
         w = {{(WAIT_WIDTH+CSR_WIDTH-1){1'b0}}, 1'b1};
      end
      w = w - {{(WAIT_WIDTH+CSR_WIDTH-1){1'b0}}, 1'b1};
      return w[WAIT_WIDTH-1:0];
   endfunction

endpackage

>>> hw/rtl/sccb_bit_master.sv
// ----------------------------------------------------------------------------
// sccb_bit_master
// Bit-level two-wire camera-bus master driven by one tick word per cycle while ready.
// ----------------------------------------------------------------------------
// Each request word is one tick of bus timing and may carry a command (start,
// stop, no-ack, write byte, read byte) that is taken only while the master is
// idle. Every request word yields exactly one response word showing the clock
// line, data latch, data drive enable, busy, done, ack and read byte after
// that tick. One word is taken per clock: the sequencer updates its state and
// the response lands in the output register on the accepting edge; a new
// request is taken whenever that register is empty or being read in the same
// cycle. Phase lengths are set by the two wait registers; the user must write
// them via the csr port only while the bus is idle; the block does not check.
`timescale 1ns / 1ps

module sccb_bit_master
   import sbm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [2:0]                 req_kind,
   input  logic [7:0]                 req_write_byte,
   input  logic                       req_data_pin_in,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_clock_pin,
   output logic                       rsp_data_pin_out,
   output logic                       rsp_data_drive_enable,
   output logic                       rsp_busy_res,
   output logic                       rsp_done_res,
   output logic                       rsp_ack_ok,
   output logic [7:0]                 rsp_read_byte,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]       csr_wdata
);

   logic       step;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;

   // take a word when the output register is free or draining
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign step      = req_valid & req_ready;

   sbm_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .kind        (req_kind),
      .write_byte  (req_write_byte),
      .data_pin_in (req_data_pin_in),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .result      (result)
   );

   // output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_clock_pin         = rsp_ff.clock_pin;
   assign rsp_data_pin_out      = rsp_ff.data_pin_out;
   assign rsp_data_drive_enable = rsp_ff.data_drive_enable;
   assign rsp_busy_res          = rsp_ff.busy_res;
   assign rsp_done_res          = rsp_ff.done_res;
   assign rsp_ack_ok            = rsp_ff.ack_ok;
   assign rsp_read_byte         = rsp_ff.read_byte;

endmodule

>>> hw/rtl/sbm_seq.sv
// ----------------------------------------------------------------------------
// sbm_seq
// Phase sequencer: wait registers, bus state and next-tick logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbm_seq
   import sbm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [2:0]                 kind,
   input  logic [7:0]                 write_byte,
   input  logic                       data_pin_in,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]       csr_wdata,
   output result_type                 result
);

   logic [CSR_WIDTH-1:0]  long_wait_ff, short_wait_ff;
   phase_type             phase_ff, phase_in, target;
   logic [2:0]            cmd_ff, cmd_in;
   logic [WAIT_WIDTH-1:0] wait_ff, wait_in;
   logic [3:0]            bit_ff, bit_in;
   logic [7:0]            shift_ff, shift_in;
   logic                  clk_ff, clk_in;
   logic                  latch_ff, latch_in;
   logic                  drive_ff, drive_in;
   logic                  ack_ff, ack_in;
   logic [7:0]            rbyte_ff, rbyte_in;
   logic                  do_enter;
   logic                  done;
   logic [WAIT_WIDTH-1:0] long_load, short_load;

   assign long_load  = wait_load(long_wait_ff);
   assign short_load = wait_load(short_wait_ff);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         long_wait_ff  <= LONG_WAIT_RESET;
         short_wait_ff <= SHORT_WAIT_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_LONG_WAIT) begin
            long_wait_ff <= csr_wdata;
         end else if (csr_index == CSR_SHORT_WAIT) begin
            short_wait_ff <= csr_wdata;
         end
      end
   end

   // one tick of the sequencer
   always_comb begin
      phase_in = phase_ff;
      cmd_in   = cmd_ff;
      wait_in  = wait_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      clk_in   = clk_ff;
      latch_in = latch_ff;
      drive_in = drive_ff;
      ack_in   = ack_ff;
      rbyte_in = rbyte_ff;
      target   = PH_FIN;
      do_enter = 1'b0;
      done     = 1'b0;

      // pick the phase to enter, if any
      if (step) begin
         if (phase_ff == PH_IDLE) begin
            if (kind >= KIND_START && kind <= KIND_NACK) begin
               do_enter = 1'b1;
               cmd_in   = kind;
               bit_in   = 4'd0;
               shift_in = (kind == KIND_WRITE) ? write_byte : 8'd0;
               case (kind)
                  KIND_START: target = PH_S_DH;
                  KIND_STOP:  target = PH_P_DL;
                  KIND_WRITE: target = PH_W_BIT;
                  KIND_READ:  target = PH_R_REL;
                  default:    target = PH_N_DH;
               endcase
            end
         end else if (wait_ff != '0) begin
            wait_in = wait_ff - {{(WAIT_WIDTH-1){1'b0}}, 1'b1};
         end else begin
            do_enter = 1'b1;
            case (phase_ff)
               PH_S_DH:  target = PH_S_CH;
               PH_S_CH:  target = PH_S_DL;
               PH_S_DL:  target = PH_S_CL;
               PH_P_DL:  target = PH_P_CH;
               PH_P_CH:  target = PH_P_DH;
               PH_N_DH:  target = PH_N_CH;
               PH_N_CH:  target = PH_N_CL;
               PH_N_CL:  target = PH_N_DL;
               PH_W_BIT: target = PH_W_CH;
               PH_W_CH:  target = PH_W_CL;
               PH_W_CL: begin
                  bit_in = bit_ff + 4'd1;
                  target = (bit_in < BYTE_BITS) ? PH_W_BIT : PH_W_GAP;
               end
               PH_W_GAP: target = PH_W_REL;
               PH_W_REL: target = PH_W_ACH;
               PH_W_ACH: target = PH_W_ACL;
               PH_R_REL: target = PH_R_PRE;
               PH_R_PRE: target = PH_R_CH;
               PH_R_CH:  target = PH_R_CL;
               PH_R_CL: begin
                  bit_in = bit_ff + 4'd1;
                  target = (bit_in < BYTE_BITS) ? PH_R_PRE : PH_FIN;
               end
               default:  target = PH_FIN;
            endcase
         end
      end

      // action of the phase being entered
      if (do_enter) begin
         phase_in = target;
         case (target)
            PH_S_DH, PH_N_DH, PH_P_DH: begin
               latch_in = 1'b1;
               wait_in  = long_load;
            end
            PH_S_DL, PH_P_DL, PH_N_DL: begin
               latch_in = 1'b0;
               wait_in  = long_load;
            end
            PH_S_CH, PH_P_CH, PH_N_CH, PH_W_CH, PH_R_CH: begin
               clk_in  = 1'b1;
               wait_in = long_load;
            end
            PH_S_CL, PH_N_CL, PH_W_CL: begin
               clk_in  = 1'b0;
               wait_in = long_load;
            end
            PH_W_BIT: begin
               // msb first
               latch_in = shift_in[3'd7 - bit_in[2:0]];
               wait_in  = long_load;
            end
            PH_W_GAP: wait_in = short_load;
            PH_W_REL: begin
               drive_in = 1'b0;
               wait_in  = long_load;
            end
            PH_W_ACH: begin
               clk_in  = 1'b1;
               wait_in = short_load;
            end
            PH_W_ACL: begin
               // low data line is an acknowledge
               ack_in  = ~data_pin_in;
               clk_in  = 1'b0;
               wait_in = long_load;
            end
            PH_R_REL: begin
               drive_in = 1'b0;
               shift_in = 8'd0;
               bit_in   = 4'd0;
               wait_in  = long_load;
            end
            PH_R_PRE: wait_in = long_load;
            PH_R_CL: begin
               shift_in = {shift_in[6:0], data_pin_in};
               clk_in   = 1'b0;
               wait_in  = long_load;
            end
            default: begin
               // closing step
               if (cmd_in == KIND_READ) begin
                  rbyte_in = shift_in;
               end
               if (cmd_in == KIND_WRITE || cmd_in == KIND_READ) begin
                  drive_in = 1'b1;
               end
               phase_in = PH_IDLE;
               wait_in  = '0;
               done     = 1'b1;
            end
         endcase
      end
   end

   // bus state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cmd_ff   <= KIND_TICK;
         wait_ff  <= '0;
         bit_ff   <= 4'd0;
         shift_ff <= 8'd0;
         clk_ff   <= 1'b1;
         latch_ff <= 1'b1;
         drive_ff <= 1'b1;
         ack_ff   <= 1'b0;
         rbyte_ff <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         cmd_ff   <= cmd_in;
         wait_ff  <= wait_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         clk_ff   <= clk_in;
         latch_ff <= latch_in;
         drive_ff <= drive_in;
         ack_ff   <= ack_in;
         rbyte_ff <= rbyte_in;
      end
   end

   // result word for this tick
   assign result.clock_pin         = clk_in;
   assign result.data_pin_out      = latch_in;
   assign result.data_drive_enable = drive_in;
   assign result.busy_res          = (phase_in != PH_IDLE);
   assign result.done_res          = done;
   assign result.ack_ok            = ack_in;
   assign result.read_byte         = rbyte_in;

endmodule

>>> hw/rtl/sbm_checker.sv
// ----------------------------------------------------------------------------
// sbm_checker
// Port-level checks for the camera-bus bit master, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sccb_bit_master_defines.svh"

module sbm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_data_drive_enable,
   input logic       rsp_busy_res,
   input logic       rsp_done_res,
   input logic [7:0] rsp_read_byte
);

   // response fields watched while a word waits
   logic [9:0] rsp_probe;

   assign rsp_probe = {rsp_busy_res, rsp_done_res, rsp_read_byte};

   // a stalled response word holds
   `SBM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_probe))

   // the finishing word is never busy
   `SBM_ASSERT_NOW(a_done_idle, rsp_valid && rsp_done_res, !rsp_busy_res)

   // data is released only inside a command
   `SBM_ASSERT_NOW(a_release_busy, rsp_valid && !rsp_data_drive_enable, rsp_busy_res)

   // an empty output register never blocks the request side
   `SBM_ASSERT_NOW(a_ready_empty, !rsp_valid, req_ready)

endmodule

bind sccb_bit_master sbm_checker u_sbm_checker (.*);

>>> bench/sbm_pin_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbm_pin_checker
// Follows the camera-bus sequencer one tick per accepted request word, keeps
// the expected response words in order and compares every response field.
// ----------------------------------------------------------------------------

module sbm_pin_checker
   import sbm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [2:0]                 req_kind,
   input  logic [7:0]                 req_write_byte,
   input  logic                       req_data_pin_in,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic                       rsp_clock_pin,
   input  logic                       rsp_data_pin_out,
   input  logic                       rsp_data_drive_enable,
   input  logic                       rsp_busy_res,
   input  logic                       rsp_done_res,
   input  logic                       rsp_ack_ok,
   input  logic [7:0]                 rsp_read_byte,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]       csr_wdata,
   output int unsigned                mismatch_count,
   output int unsigned                words_pending,
   output logic                       bus_busy
);

   // hold times as last written
   logic [CSR_WIDTH-1:0]  long_ticks;
   logic [CSR_WIDTH-1:0]  short_ticks;

   // predicted sequencer state
   phase_type             phase_now;
   logic [2:0]            command;
   logic [WAIT_WIDTH-1:0] hold_left;
   logic [3:0]            bit_no;
   logic [7:0]            shift_reg;
   logic                  scl_level;
   logic                  sda_latch;
   logic                  sda_drive;
   logic                  ack_seen;
   logic                  closing;
   logic [7:0]            last_read;

   // expected response words, oldest first
   result_type            expected_pins[$];
   int unsigned           word_no;

   assign bus_busy = (phase_now != PH_IDLE);

   // counter load for a hold time: zero holds one tick, clipped to counter range
   function automatic logic [WAIT_WIDTH-1:0] hold_load(input logic [CSR_WIDTH-1:0] ticks);
      longint unsigned n;
      longint unsigned ceiling;
      ceiling = (64'd1 << WAIT_WIDTH) - 64'd1;
      n = ticks;
      if (n > ceiling) begin
         n = ceiling;
      end
      if (n == 0) begin
         n = 1;
      end
      return WAIT_WIDTH'(n - 1);
   endfunction

   // action taken on the tick a phase is entered
   function automatic void enter_phase(input phase_type ph, input logic din);
      logic [7:0] shifted;
      phase_now = ph;
      case (ph)
         PH_S_DH, PH_N_DH, PH_P_DH: begin
            sda_latch = 1'b1;
            hold_left = hold_load(long_ticks);
         end
         PH_S_DL, PH_P_DL, PH_N_DL: begin
            sda_latch = 1'b0;
            hold_left = hold_load(long_ticks);
         end
         PH_S_CH, PH_P_CH, PH_N_CH, PH_W_CH, PH_R_CH: begin
            scl_level = 1'b1;
            hold_left = hold_load(long_ticks);
         end
         PH_S_CL, PH_N_CL, PH_W_CL: begin
            scl_level = 1'b0;
            hold_left = hold_load(long_ticks);
         end
         PH_W_BIT: begin
            // msb first
            shifted   = shift_reg << bit_no[2:0];
            sda_latch = shifted[7];
            hold_left = hold_load(long_ticks);
         end
         PH_W_GAP: begin
            hold_left = hold_load(short_ticks);
         end
         PH_W_REL: begin
            sda_drive = 1'b0;
            hold_left = hold_load(long_ticks);
         end
         PH_W_ACH: begin
            scl_level = 1'b1;
            hold_left = hold_load(short_ticks);
         end
         PH_W_ACL: begin
            // slave pulling the line low acknowledges
            ack_seen  = ~din;
            scl_level = 1'b0;
            hold_left = hold_load(long_ticks);
         end
         PH_R_REL: begin
            sda_drive = 1'b0;
            shift_reg = 8'h00;
            bit_no    = '0;
            hold_left = hold_load(long_ticks);
         end
         PH_R_PRE: begin
            hold_left = hold_load(long_ticks);
         end
         PH_R_CL: begin
            shift_reg = {shift_reg[6:0], din};
            scl_level = 1'b0;
            hold_left = hold_load(long_ticks);
         end
         default: begin
            // closing step: data line driven again, latch keeps its level
            if (command == KIND_READ) begin
               last_read = shift_reg;
            end
            if (command == KIND_WRITE || command == KIND_READ) begin
               sda_drive = 1'b1;
            end
            phase_now = PH_IDLE;
            hold_left = '0;
            closing   = 1'b1;
         end
      endcase
   endfunction

   // phase order, with the bit count stepped at the end of each data bit
   function automatic phase_type next_phase(input phase_type ph);
      case (ph)
         PH_S_DH:  return PH_S_CH;
         PH_S_CH:  return PH_S_DL;
         PH_S_DL:  return PH_S_CL;
         PH_P_DL:  return PH_P_CH;
         PH_P_CH:  return PH_P_DH;
         PH_N_DH:  return PH_N_CH;
         PH_N_CH:  return PH_N_CL;
         PH_N_CL:  return PH_N_DL;
         PH_W_BIT: return PH_W_CH;
         PH_W_CH:  return PH_W_CL;
         PH_W_CL: begin
            bit_no = bit_no + 4'd1;
            return (bit_no < BYTE_BITS) ? PH_W_BIT : PH_W_GAP;
         end
         PH_W_GAP: return PH_W_REL;
         PH_W_REL: return PH_W_ACH;
         PH_W_ACH: return PH_W_ACL;
         PH_R_REL: return PH_R_PRE;
         PH_R_PRE: return PH_R_CH;
         PH_R_CH:  return PH_R_CL;
         PH_R_CL: begin
            bit_no = bit_no + 4'd1;
            return (bit_no < BYTE_BITS) ? PH_R_PRE : PH_FIN;
         end
         default:  return PH_FIN;
      endcase
   endfunction

   // one tick of the sequencer, returns the pins after the tick
   function automatic result_type predict_tick(input logic [2:0] kind,
                                               input logic [7:0] wbyte,
                                               input logic       din);
      result_type pins;
      closing = 1'b0;
      if (phase_now == PH_IDLE) begin
         // commands are taken only while idle
         if (kind >= KIND_START && kind <= KIND_NACK) begin
            command   = kind;
            bit_no    = '0;
            shift_reg = (kind == KIND_WRITE) ? wbyte : 8'h00;
            case (kind)
               KIND_START: enter_phase(PH_S_DH, din);
               KIND_STOP:  enter_phase(PH_P_DL, din);
               KIND_WRITE: enter_phase(PH_W_BIT, din);
               KIND_READ:  enter_phase(PH_R_REL, din);
               default:    enter_phase(PH_N_DH, din);
            endcase
         end
      end else if (hold_left != '0) begin
         hold_left = hold_left - 1'b1;
      end else begin
         enter_phase(next_phase(phase_now), din);
      end
      pins.clock_pin         = scl_level;
      pins.data_pin_out      = sda_latch;
      pins.data_drive_enable = sda_drive;
      pins.busy_res          = (phase_now != PH_IDLE);
      pins.done_res          = closing;
      pins.ack_ok            = ack_seen;
      pins.read_byte         = last_read;
      return pins;
   endfunction

   function automatic void clear_model();
      long_ticks  = LONG_WAIT_RESET;
      short_ticks = SHORT_WAIT_RESET;
      phase_now   = PH_IDLE;
      command     = KIND_TICK;
      hold_left   = '0;
      bit_no      = '0;
      shift_reg   = 8'h00;
      scl_level   = 1'b1;
      sda_latch   = 1'b1;
      sda_drive   = 1'b1;
      ack_seen    = 1'b0;
      closing     = 1'b0;
      last_read   = 8'h00;
      word_no     = 0;
      expected_pins.delete();
   endfunction

   task automatic report_mismatch(input string what);
      // keep the log short when the block is badly off
      if (mismatch_count < 40) begin
         $display("[%0t] mismatch: %s", $time, what);
      end
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want) begin
         report_mismatch($sformatf("word %0d %s got %0h want %0h", word_no, name, got, want));
      end
   endtask

   // responses are compared before the request of the same edge is predicted
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         clear_model();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pins.size() == 0) begin
               report_mismatch($sformatf("word %0d arrived with nothing expected", word_no));
            end else begin
               want = expected_pins.pop_front();
               check_field("clock_pin", rsp_clock_pin, want.clock_pin);
               check_field("data_pin_out", rsp_data_pin_out, want.data_pin_out);
               check_field("data_drive_enable", rsp_data_drive_enable,
                           want.data_drive_enable);
               check_field("busy_res", rsp_busy_res, want.busy_res);
               check_field("done_res", rsp_done_res, want.done_res);
               check_field("ack_ok", rsp_ack_ok, want.ack_ok);
               check_field("read_byte", rsp_read_byte, want.read_byte);
            end
            word_no++;
         end
         if (req_valid && req_ready) begin
            expected_pins.push_back(predict_tick(req_kind, req_write_byte, req_data_pin_in));
         end
         // register writes, unmapped indexes have no effect
         if (csr_we) begin
            case (csr_index)
               CSR_LONG_WAIT:  long_ticks  = csr_wdata;
               CSR_SHORT_WAIT: short_ticks = csr_wdata;
               default: ;
            endcase
         end
      end
      words_pending = expected_pins.size();
   end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the camera-bus bit master with tick words: directed commands at the
// edges of timing and data, then random command streams under three idling
// mixes. The pin checker predicts and compares every response word.
// ----------------------------------------------------------------------------

module tb
   import sbm_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT = 4_000_000;

   // spare kind codes, decoded as a plain tick
   localparam logic [2:0] KIND_SPARE_6 = 3'd6;
   localparam logic [2:0] KIND_SPARE_7 = 3'd7;

   // register indexes with nothing behind them
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED_2 = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED_3 = 2'd3;

   // level of the sampled data line while a command runs
   typedef enum int {DIN_LOW, DIN_HIGH, DIN_RANDOM} din_mode_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [2:0]                 req_kind = KIND_TICK;
   logic [7:0]                 req_write_byte = 8'h00;
   logic                       req_data_pin_in = 1'b1;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_clock_pin;
   logic                       rsp_data_pin_out;
   logic                       rsp_data_drive_enable;
   logic                       rsp_busy_res;
   logic                       rsp_done_res;
   logic                       rsp_ack_ok;
   logic [7:0]                 rsp_read_byte;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_LONG_WAIT;
   logic [CSR_WIDTH-1:0]       csr_wdata = '0;

   int unsigned                mismatch_count;
   int unsigned                words_pending;
   logic                       bus_busy;

   int unsigned                send_gap_pct = 0;
   int unsigned                stall_pct = 0;
   int unsigned                words_sent = 0;
   int unsigned                cycle_count = 0;

   sccb_bit_master dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_kind              (req_kind),
      .req_write_byte        (req_write_byte),
      .req_data_pin_in       (req_data_pin_in),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_clock_pin         (rsp_clock_pin),
      .rsp_data_pin_out      (rsp_data_pin_out),
      .rsp_data_drive_enable (rsp_data_drive_enable),
      .rsp_busy_res          (rsp_busy_res),
      .rsp_done_res          (rsp_done_res),
      .rsp_ack_ok            (rsp_ack_ok),
      .rsp_read_byte         (rsp_read_byte),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   sbm_pin_checker pin_check (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_kind              (req_kind),
      .req_write_byte        (req_write_byte),
      .req_data_pin_in       (req_data_pin_in),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_clock_pin         (rsp_clock_pin),
      .rsp_data_pin_out      (rsp_data_pin_out),
      .rsp_data_drive_enable (rsp_data_drive_enable),
      .rsp_busy_res          (rsp_busy_res),
      .rsp_done_res          (rsp_done_res),
      .rsp_ack_ok            (rsp_ack_ok),
      .rsp_read_byte         (rsp_read_byte),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .mismatch_count        (mismatch_count),
      .words_pending         (words_pending),
      .bus_busy              (bus_busy)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // hard stop if the run hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // response side stalls at random
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic logic line_level(input din_mode_type mode);
      case (mode)
         DIN_LOW:  return 1'b0;
         DIN_HIGH: return 1'b1;
         default:  return 1'($urandom_range(1));
      endcase
   endfunction

   // one request word; starts and ends at a falling edge
   task automatic send_word(input logic [2:0] kind, input logic [7:0] wbyte,
                            input logic din);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_write_byte  <= wbyte;
      req_data_pin_in <= din;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      words_sent++;
      @(negedge clock);
   endtask

   // a command word, then ticks until the sequencer is idle again;
   // noisy ticks carry commands that a busy sequencer must ignore
   task automatic run_command(input logic [2:0] kind, input logic [7:0] wbyte,
                              input din_mode_type mode, input bit noisy);
      send_word(kind, wbyte, line_level(mode));
      while (bus_busy) begin
         if (noisy) begin
            send_word(3'($urandom_range(KIND_START, KIND_SPARE_7)), 8'($urandom),
                      line_level(mode));
         end else begin
            send_word(KIND_TICK, 8'($urandom), line_level(mode));
         end
      end
   endtask

   // stop sending and wait for every expected word
   task automatic drain();
      req_valid <= 1'b0;
      while (words_pending != 0) begin
         @(negedge clock);
      end
   endtask

   // both hold times, then a write to an unmapped index
   task automatic write_regs(input logic [CSR_WIDTH-1:0] long_w,
                             input logic [CSR_WIDTH-1:0] short_w);
      drain();
      csr_we    <= 1'b1;
      csr_index <= CSR_LONG_WAIT;
      csr_wdata <= long_w;
      @(negedge clock);
      csr_index <= CSR_SHORT_WAIT;
      csr_wdata <= short_w;
      @(negedge clock);
      csr_index <= $urandom_range(1) ? CSR_UNMAPPED_2 : CSR_UNMAPPED_3;
      csr_wdata <= CSR_WIDTH'($urandom);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // mostly complete commands with random content, some idle noise words
   task automatic random_traffic(input int unsigned budget);
      int unsigned  stop_at;
      din_mode_type mode;
      stop_at = words_sent + budget;
      while (words_sent < stop_at) begin
         mode = ($urandom_range(3) == 0) ? din_mode_type'($urandom_range(DIN_HIGH)) : DIN_RANDOM;
         case ($urandom_range(11))
            0: send_word(KIND_TICK, 8'($urandom), 1'($urandom_range(1)));
            1: send_word($urandom_range(1) ? KIND_SPARE_6 : KIND_SPARE_7, 8'($urandom),
                         1'($urandom_range(1)));
            default: run_command(3'($urandom_range(KIND_START, KIND_NACK)), 8'($urandom),
                                 mode, $urandom_range(3) == 0);
         endcase
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sender seldom idles, receiver mostly stalls
      send_gap_pct = 11;
      stall_pct    = 85;

      // zero hold times act as one tick
      write_regs('0, '0);
      run_command(KIND_START, 8'h00, DIN_RANDOM, 1'b0);
      run_command(KIND_STOP, 8'hFF, DIN_RANDOM, 1'b0);
      run_command(KIND_NACK, 8'h00, DIN_RANDOM, 1'b0);
      run_command(KIND_WRITE, 8'h00, DIN_LOW, 1'b0);
      run_command(KIND_WRITE, 8'hFF, DIN_HIGH, 1'b0);
      run_command(KIND_WRITE, 8'h80, DIN_RANDOM, 1'b0);
      run_command(KIND_WRITE, 8'h01, DIN_RANDOM, 1'b0);
      run_command(KIND_READ, 8'h00, DIN_HIGH, 1'b0);
      run_command(KIND_READ, 8'hFF, DIN_LOW, 1'b0);
      run_command(KIND_READ, 8'h5A, DIN_RANDOM, 1'b0);
      send_word(KIND_SPARE_6, 8'hFF, 1'b0);
      send_word(KIND_SPARE_7, 8'h00, 1'b1);
      // commands or spare codes on every busy tick, the closing one included
      run_command(KIND_START, 8'h3C, DIN_RANDOM, 1'b1);
      run_command(KIND_WRITE, 8'hC3, DIN_RANDOM, 1'b1);
      run_command(KIND_READ, 8'h00, DIN_RANDOM, 1'b1);

      // uneven hold times
      write_regs(CSR_WIDTH'(2), CSR_WIDTH'(1));
      run_command(KIND_WRITE, 8'h96, DIN_RANDOM, 1'b0);
      run_command(KIND_READ, 8'h00, DIN_RANDOM, 1'b0);
      write_regs(CSR_WIDTH'(1), CSR_WIDTH'(3));
      run_command(KIND_WRITE, 8'h69, DIN_RANDOM, 1'b0);
      run_command(KIND_NACK, 8'h00, DIN_RANDOM, 1'b0);

      write_regs(CSR_WIDTH'($urandom_range(0, 3)), CSR_WIDTH'($urandom_range(0, 3)));
      random_traffic(30);
      write_regs(CSR_WIDTH'($urandom_range(0, 3)), CSR_WIDTH'($urandom_range(0, 3)));
      random_traffic(30);

      // sender mostly idles, receiver seldom stalls
      send_gap_pct = 85;
      stall_pct    = 11;
      write_regs(CSR_WIDTH'($urandom_range(0, 3)), CSR_WIDTH'($urandom_range(0, 3)));
      random_traffic(30);
      write_regs(CSR_WIDTH'($urandom_range(0, 3)), CSR_WIDTH'($urandom_range(0, 3)));
      random_traffic(30);

      // no idling on either side
      send_gap_pct = 0;
      stall_pct    = 0;
      write_regs(CSR_WIDTH'(1), CSR_WIDTH'(2));
      random_traffic(30);
      write_regs(CSR_WIDTH'($urandom_range(0, 3)), CSR_WIDTH'($urandom_range(0, 3)));
      random_traffic(30);

      // let any stray word show up before the verdict
      drain();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/sbm_pkg.sv
hw/rtl/sbm_seq.sv
hw/rtl/sccb_bit_master.sv
hw/rtl/sbm_checker.sv
bench/sbm_pin_checker.sv
bench/tb.sv
